### sv/sjc_pkg.sv
// Package for the servo jog controller: field widths, angle constants,
// configuration register indexes and reset values. No dependencies.
package sjc_pkg;

    localparam int STICK_W = 7;
    localparam int ANGLE_W = 8;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;

    localparam logic [ANGLE_W-1:0] SERVO_MAX   = 8'd180;
    localparam logic [ANGLE_W-1:0] ANGLE_RESET = 8'd90;
    localparam logic [STICK_W-1:0] STICK_HIGH  = 7'd100;
    localparam logic [STICK_W-1:0] STICK_MID   = 7'd50;

    localparam logic [ANGLE_W-1:0] A_LO_RESET   = 8'd50;
    localparam logic [ANGLE_W-1:0] A_HI_RESET   = 8'd90;
    localparam logic [ANGLE_W-1:0] B_LO_RESET   = 8'd50;
    localparam logic [ANGLE_W-1:0] B_HI_RESET   = 8'd115;
    localparam logic [ANGLE_W-1:0] Z_HI_RESET   = 8'd180;
    localparam logic [ANGLE_W-1:0] Z_HOME_RESET = 8'd90;

    typedef enum logic [2:0] {
        CFG_A_LO   = 3'd0,
        CFG_A_HI   = 3'd1,
        CFG_B_LO   = 3'd2,
        CFG_B_HI   = 3'd3,
        CFG_Z_HI   = 3'd4,
        CFG_Z_HOME = 3'd5
    } t_cfg_idx;

endpackage

### sv/sjc_if.sv
// Valid/ready channel interfaces for the servo jog controller:
// the control frame channel and the report channel. Uses sjc_pkg.
interface sjc_in_if;
    import sjc_pkg::*;
    logic               valid;
    logic               ready;
    logic [STICK_W-1:0] stick_x;
    logic [STICK_W-1:0] stick_y;
    logic               raise_button;
    logic               lower_button;
    logic               grip_button;
    logic               control_off;
    logic               home_request;

    modport source (output valid, stick_x, stick_y, raise_button, lower_button,
                    grip_button, control_off, home_request, input ready);
    modport sink   (input valid, stick_x, stick_y, raise_button, lower_button,
                    grip_button, control_off, home_request, output ready);
endinterface

interface sjc_out_if;
    import sjc_pkg::*;
    logic               valid;
    logic               ready;
    logic [ANGLE_W-1:0] report_a;
    logic [ANGLE_W-1:0] report_b;
    logic [ANGLE_W-1:0] report_z;
    logic [ANGLE_W-1:0] grip_drive;
    logic               grip_closed;

    modport source (output valid, report_a, report_b, report_z, grip_drive,
                    grip_closed, input ready);
    modport sink   (input valid, report_a, report_b, report_z, grip_drive,
                    grip_closed, output ready);
endinterface

### sv/servo_jog_controller_unit.sv
// Servo jog controller top level: frame input register, jog/clamp/home
// logic, report register and APB register file. Uses sjc_pkg and sjc_if.
//
// Usage: control frames arrive on i_in (valid/ready), one report item per
// frame leaves on o_out (valid/ready). The limit registers sit on the APB
// port at byte addresses 0,4,..,20; data whose low byte is above 180 saturates
// to 180, writes beyond the last register are dropped. Write them only while idle.
// An accepted item is registered in the input register, then processed into
// the axis state registers, which also serve as the report register.
// Throughput: one item per cycle while o_out is not stalled; the axis state is
// read and updated in the single processing stage, so items chain without bubbles.
// Stall: when o_out.ready is low the report register holds, the input
// register still takes one more item, then i_in.ready drops until the
// report is taken. Nothing is lost or repeated.
// Reset (synchronous, active low): all axes and the gripper go to 90
// degrees, gripper toggle cleared, push button taken as released, status
// open, registers to their defaults, both pipeline stages empty.
module servo_jog_controller_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    sjc_in_if.sink                     i_in,
    sjc_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sjc_pkg::APB_AW-1:0] paddr,
    input  logic [sjc_pkg::APB_DW-1:0] pwdata,
    output logic [sjc_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import sjc_pkg::*;

    // configuration registers
    logic [ANGLE_W-1:0] r_a_lo, r_a_hi, r_b_lo, r_b_hi, r_z_hi, r_z_home;
    logic [ANGLE_W-1:0] w_cfg_val;
    logic [2:0]         w_cfg_idx;
    logic               w_cfg_wr;

    // input stage
    logic               r_in_v;
    logic [STICK_W-1:0] r_sx, r_sy;
    logic               r_raise, r_lower, r_grip, r_ctl_off, r_home;

    // axis state
    logic [ANGLE_W-1:0] r_ang_a, r_ang_b, r_ang_z, r_grip_ang;
    logic               r_parity, r_last_grip, r_grip_stat;
    logic [ANGLE_W-1:0] n_ang_a, n_ang_b, n_ang_z, n_grip_ang;
    logic               n_parity, n_last_grip, n_grip_stat;

    // output stage
    logic               r_out_v;
    logic               w_adv;
    logic [ANGLE_W-1:0] w_g;

    function automatic logic [ANGLE_W-1:0] jog_axis(
        input logic [ANGLE_W-1:0] ang,
        input logic [STICK_W-1:0] stick,
        input logic [ANGLE_W-1:0] lo,
        input logic [ANGLE_W-1:0] hi
    );
        logic [STICK_W-1:0] s;
        logic [ANGLE_W-1:0] res;
        s   = (stick > STICK_HIGH) ? STICK_HIGH : stick;
        res = ang;
        if (s >= STICK_MID) begin
            if (ang < hi) begin
                if (s == STICK_HIGH) res = ang + 8'd1;
            end else begin
                res = hi;
            end
        end else begin
            if (ang > lo) begin
                if (s == '0) res = ang - 8'd1;
            end else begin
                res = lo;
            end
        end
        return res;
    endfunction

    // ---------------- APB ----------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cfg_idx = paddr[4:2];
    assign w_cfg_val = (pwdata[ANGLE_W-1:0] > SERVO_MAX) ? SERVO_MAX
                                                         : pwdata[ANGLE_W-1:0];

    always_comb begin
        unique case (w_cfg_idx)
            CFG_A_LO:   prdata = {{(APB_DW-ANGLE_W){1'b0}}, r_a_lo};
            CFG_A_HI:   prdata = {{(APB_DW-ANGLE_W){1'b0}}, r_a_hi};
            CFG_B_LO:   prdata = {{(APB_DW-ANGLE_W){1'b0}}, r_b_lo};
            CFG_B_HI:   prdata = {{(APB_DW-ANGLE_W){1'b0}}, r_b_hi};
            CFG_Z_HI:   prdata = {{(APB_DW-ANGLE_W){1'b0}}, r_z_hi};
            CFG_Z_HOME: prdata = {{(APB_DW-ANGLE_W){1'b0}}, r_z_home};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_lo   <= A_LO_RESET;
            r_a_hi   <= A_HI_RESET;
            r_b_lo   <= B_LO_RESET;
            r_b_hi   <= B_HI_RESET;
            r_z_hi   <= Z_HI_RESET;
            r_z_home <= Z_HOME_RESET;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                CFG_A_LO:   r_a_lo   <= w_cfg_val;
                CFG_A_HI:   r_a_hi   <= w_cfg_val;
                CFG_B_LO:   r_b_lo   <= w_cfg_val;
                CFG_B_HI:   r_b_hi   <= w_cfg_val;
                CFG_Z_HI:   r_z_hi   <= w_cfg_val;
                CFG_Z_HOME: r_z_home <= w_cfg_val;
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    assign w_adv      = r_in_v && (!r_out_v || o_out.ready);
    assign i_in.ready = !r_in_v || w_adv;

    // ---------------- frame processing ----------------
    always_comb begin
        n_ang_a     = r_ang_a;
        n_ang_b     = r_ang_b;
        n_ang_z     = r_ang_z;
        n_grip_ang  = r_grip_ang;
        n_parity    = r_parity;
        n_last_grip = r_last_grip;
        n_grip_stat = r_grip_stat;
        w_g         = r_ang_b;

        if (!r_ctl_off) begin
            // toggle on a press (falling edge of the active-low button)
            if (r_grip != r_last_grip) begin
                if (!r_grip) n_parity = !r_parity;
                n_last_grip = r_grip;
            end
            n_grip_ang  = n_parity ? '0 : SERVO_MAX;
            n_grip_stat = !n_parity;

            n_ang_z = jog_axis(r_ang_z, r_sx, '0, r_z_hi);
            n_ang_a = jog_axis(r_ang_a, r_sy, r_a_lo, r_a_hi);

            // lower step works on the raised copy, not on the clamp write
            if (!r_raise) begin
                if (w_g < r_b_hi) begin
                    w_g     = w_g + 8'd1;
                    n_ang_b = w_g;
                end else begin
                    n_ang_b = r_b_hi;
                end
            end
            if (!r_lower) begin
                if (w_g > r_b_lo) begin
                    n_ang_b = w_g - 8'd1;
                end else begin
                    n_ang_b = r_b_lo;
                end
            end
        end

        if (r_home) begin
            n_grip_ang = '0;
            n_ang_b    = r_b_hi;
            n_ang_a    = r_a_lo;
            n_ang_z    = r_z_home;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v      <= 1'b0;
            r_out_v     <= 1'b0;
            r_ang_a     <= ANGLE_RESET;
            r_ang_b     <= ANGLE_RESET;
            r_ang_z     <= ANGLE_RESET;
            r_grip_ang  <= ANGLE_RESET;
            r_parity    <= 1'b0;
            r_last_grip <= 1'b1;
            r_grip_stat <= 1'b0;
        end else begin
            if (i_in.ready) r_in_v <= i_in.valid;
            if (w_adv) begin
                r_out_v     <= 1'b1;
                r_ang_a     <= n_ang_a;
                r_ang_b     <= n_ang_b;
                r_ang_z     <= n_ang_z;
                r_grip_ang  <= n_grip_ang;
                r_parity    <= n_parity;
                r_last_grip <= n_last_grip;
                r_grip_stat <= n_grip_stat;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // input payload register
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_sx      <= i_in.stick_x;
            r_sy      <= i_in.stick_y;
            r_raise   <= i_in.raise_button;
            r_lower   <= i_in.lower_button;
            r_grip    <= i_in.grip_button;
            r_ctl_off <= i_in.control_off;
            r_home    <= i_in.home_request;
        end
    end

    // the state registers double as the report register
    assign o_out.valid       = r_out_v;
    assign o_out.report_a    = r_ang_a;
    assign o_out.report_b    = r_ang_b;
    assign o_out.report_z    = r_ang_z;
    assign o_out.grip_drive  = r_grip_ang;
    assign o_out.grip_closed = r_grip_stat;

endmodule

### dv/servo_jog_controller_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for servo_jog_controller_unit: drives control frames and APB limit
// writes, predicts every report item and checks it. Uses sjc_pkg and sjc_if.
module servo_jog_controller_unit_tb;
    import sjc_pkg::*;

    localparam int NUM_LIMITS  = 6;
    localparam int REG_STRIDE  = 4;
    localparam int MAX_SHOWN   = 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [APB_AW-1:0] UNMAPPED_ADDR = APB_AW'(NUM_LIMITS * REG_STRIDE);

    typedef struct packed {
        logic [STICK_W-1:0] stick_x;
        logic [STICK_W-1:0] stick_y;
        logic               raise_button;
        logic               lower_button;
        logic               grip_button;
        logic               control_off;
        logic               home_request;
    } frame_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] a;
        logic [ANGLE_W-1:0] b;
        logic [ANGLE_W-1:0] z;
        logic [ANGLE_W-1:0] grip;
        logic               closed;
    } report_t;

    typedef enum {DRIVE_DOWN, DRIVE_UP, DRIVE_ANY} stick_mode_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    sjc_in_if  frame_ch ();
    sjc_out_if report_ch ();

    servo_jog_controller_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (frame_ch),
        .o_out   (report_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // arm model state and limit registers
    logic [ANGLE_W-1:0] arm_a, arm_b, arm_z, grip_pos;
    logic               grip_toggle, grip_btn_prev, grip_is_closed;
    logic [ANGLE_W-1:0] lim [NUM_LIMITS];

    report_t report_q [$];
    int      fail_count  = 0;
    int      cycle_count = 0;
    int      rx_hold     = 0;
    bit      tx_steady   = 0;
    bit      rx_steady   = 0;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [STICK_W-1:0] pick_stick(stick_mode_t mode);
        case (mode)
            DRIVE_DOWN: return ($urandom_range(4) == 0) ? STICK_W'($urandom_range(1, 49)) : '0;
            DRIVE_UP: return ($urandom_range(4) == 0) ? STICK_W'($urandom_range(50, 127))
                                                      : STICK_HIGH;
            default: return STICK_W'($urandom_range(127));
        endcase
    endfunction

    function automatic frame_t pack_frame(int unsigned sx, int unsigned sy, bit raise_b,
                                          bit lower_b, bit grip_b, bit ctl_off, bit home);
        frame_t f;
        f.stick_x      = STICK_W'(sx);
        f.stick_y      = STICK_W'(sy);
        f.raise_button = raise_b;
        f.lower_button = lower_b;
        f.grip_button  = grip_b;
        f.control_off  = ctl_off;
        f.home_request = home;
        return f;
    endfunction

    function automatic logic [ANGLE_W-1:0] jog_step(logic [ANGLE_W-1:0] ang,
                                                    logic [STICK_W-1:0] stick,
                                                    logic [ANGLE_W-1:0] lo,
                                                    logic [ANGLE_W-1:0] hi);
        logic [STICK_W-1:0] s;
        s = (stick > STICK_HIGH) ? STICK_HIGH : stick;
        if (s >= STICK_MID) begin
            if (ang < hi) begin
                if (s == STICK_HIGH) ang = ang + 1'b1;
            end else begin
                ang = hi;
            end
        end else begin
            if (ang > lo) begin
                if (s == '0) ang = ang - 1'b1;
            end else begin
                ang = lo;
            end
        end
        return ang;
    endfunction

    function automatic report_t advance_arm(frame_t f);
        report_t            r;
        logic [ANGLE_W-1:0] b_work;
        if (!f.control_off) begin
            if (f.grip_button != grip_btn_prev) begin
                if (!f.grip_button) grip_toggle = ~grip_toggle;
                grip_btn_prev = f.grip_button;
            end
            grip_pos       = grip_toggle ? '0 : SERVO_MAX;
            grip_is_closed = ~grip_toggle;
            arm_z = jog_step(arm_z, f.stick_x, '0, lim[CFG_Z_HI]);
            arm_a = jog_step(arm_a, f.stick_y, lim[CFG_A_LO], lim[CFG_A_HI]);
            // both B buttons: lower step works on the raised copy, last write wins
            b_work = arm_b;
            if (!f.raise_button) begin
                if (b_work < lim[CFG_B_HI]) begin
                    b_work = b_work + 1'b1;
                    arm_b  = b_work;
                end else begin
                    arm_b = lim[CFG_B_HI];
                end
            end
            if (!f.lower_button) begin
                if (b_work > lim[CFG_B_LO]) begin
                    b_work = b_work - 1'b1;
                    arm_b  = b_work;
                end else begin
                    arm_b = lim[CFG_B_LO];
                end
            end
        end
        if (f.home_request) begin
            grip_pos = '0;
            arm_b    = lim[CFG_B_HI];
            arm_a    = lim[CFG_A_LO];
            arm_z    = lim[CFG_Z_HOME];
        end
        r.a      = arm_a;
        r.b      = arm_b;
        r.z      = arm_z;
        r.grip   = grip_pos;
        r.closed = grip_is_closed;
        return r;
    endfunction

    task automatic flag_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_SHOWN) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) flag_failure($sformatf("%s expected %0d got %0d", name, want, got));
    endtask

    // report sink: random stalls unless held steady
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            report_ch.ready <= 1'b0;
            rx_hold--;
        end else begin
            report_ch.ready <= 1'b1;
            if (!rx_steady) rx_hold = pick_gap();
        end
    end

    always @(posedge i_clk) begin : check_reports
        report_t want;
        if (i_rst_n && report_ch.valid === 1'b1 && report_ch.ready === 1'b1) begin
            if (report_q.size() == 0) begin
                flag_failure("report item with no frame pending");
            end else begin
                want = report_q.pop_front();
                compare_field("report_a", want.a, report_ch.report_a);
                compare_field("report_b", want.b, report_ch.report_b);
                compare_field("report_z", want.z, report_ch.report_z);
                compare_field("grip_drive", want.grip, report_ch.grip_drive);
                compare_field("grip_closed", want.closed, report_ch.grip_closed);
            end
        end
    end

    // called and returns just after a falling edge; valid stays up for back-to-back items
    task automatic send_frame(input frame_t f);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            frame_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        frame_ch.valid        <= 1'b1;
        frame_ch.stick_x      <= f.stick_x;
        frame_ch.stick_y      <= f.stick_y;
        frame_ch.raise_button <= f.raise_button;
        frame_ch.lower_button <= f.lower_button;
        frame_ch.grip_button  <= f.grip_button;
        frame_ch.control_off  <= f.control_off;
        frame_ch.home_request <= f.home_request;
        @(posedge i_clk);
        while (frame_ch.ready !== 1'b1) @(posedge i_clk);
        report_q.push_back(advance_arm(f));
        @(negedge i_clk);
    endtask

    task automatic settle_arm();
        frame_ch.valid <= 1'b0;
        while (report_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        int idx;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        idx = addr / REG_STRIDE;
        if (idx < NUM_LIMITS) lim[idx] = (data[7:0] > SERVO_MAX) ? SERVO_MAX : data[7:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        // the bus goes back to idle before the next transfer
        @(negedge i_clk);
    endtask

    task automatic apb_read_check(input int idx);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= APB_AW'(idx * REG_STRIDE);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        compare_field($sformatf("prdata[reg %0d]", idx), {24'b0, lim[idx]}, prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // idle first, junk in the upper data bits, one dropped write, then read back
    task automatic apply_limits(input int unsigned want_lim [NUM_LIMITS]);
        settle_arm();
        for (int i = 0; i < NUM_LIMITS; i++)
            apb_write(APB_AW'(i * REG_STRIDE), {24'($urandom), 8'(want_lim[i])});
        apb_write(UNMAPPED_ADDR, $urandom);
        for (int i = 0; i < NUM_LIMITS; i++) apb_read_check(i);
    endtask

    // segments of held stick directions so the axes reach their clamps,
    // with some fully random noise segments
    task automatic run_frames(input int n);
        int          left, seg, press_r, press_l;
        bit          noise, grip_lvl;
        stick_mode_t mode_x, mode_y;
        frame_t      f;
        left     = n;
        grip_lvl = 1'b1;
        while (left > 0) begin
            seg = ($urandom_range(7) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 40);
            if (seg > left) seg = left;
            left -= seg;
            noise   = ($urandom_range(9) == 0);
            mode_x  = stick_mode_t'($urandom_range(2));
            mode_y  = stick_mode_t'($urandom_range(2));
            press_r = $urandom_range(3);
            press_l = $urandom_range(3);
            repeat (seg) begin
                if (noise) begin
                    f = frame_t'($urandom);
                end else begin
                    if ($urandom_range(3) == 0) grip_lvl = ~grip_lvl;
                    f = pack_frame(pick_stick(mode_x), pick_stick(mode_y),
                                   !($urandom_range(2) < press_r),
                                   !($urandom_range(2) < press_l), grip_lvl,
                                   $urandom_range(11) == 0, $urandom_range(29) == 0);
                end
                send_frame(f);
            end
        end
    endtask

    function automatic int unsigned pick_limit();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 0;
        if (r == 1) return SERVO_MAX;
        if (r == 2) return $urandom_range(181, 255);
        return $urandom_range(0, 180);
    endfunction

    task automatic test_reset_state();
        for (int i = 0; i < NUM_LIMITS; i++) apb_read_check(i);
        // control off: everything ignored, reset angles reported
        send_frame(pack_frame(50, 50, 1, 1, 1, 1, 0));
        send_frame(pack_frame(75, 20, 0, 0, 0, 1, 0));
    endtask

    task automatic test_directed_frames();
        // gripper: first enabled frame closes, press toggles, hold and release do not
        send_frame(pack_frame(50, 50, 1, 1, 1, 0, 0));
        send_frame(pack_frame(50, 50, 1, 1, 0, 0, 0));
        send_frame(pack_frame(50, 50, 1, 1, 0, 0, 0));
        send_frame(pack_frame(50, 50, 1, 1, 1, 0, 0));
        send_frame(pack_frame(50, 50, 1, 1, 0, 0, 0));
        // stick extremes, above range, hold bands
        send_frame(pack_frame(100, 100, 1, 1, 1, 0, 0));
        send_frame(pack_frame(127, 0, 1, 1, 1, 0, 0));
        send_frame(pack_frame(101, 0, 1, 1, 1, 0, 0));
        send_frame(pack_frame(0, 127, 1, 1, 1, 0, 0));
        send_frame(pack_frame(49, 49, 1, 1, 1, 0, 0));
        send_frame(pack_frame(99, 99, 1, 1, 1, 0, 0));
        send_frame(pack_frame(1, 1, 1, 1, 1, 0, 0));
        send_frame(pack_frame(50, 50, 1, 1, 1, 0, 0));
        // B buttons
        send_frame(pack_frame(50, 50, 0, 1, 1, 0, 0));
        send_frame(pack_frame(50, 50, 1, 0, 1, 0, 0));
        send_frame(pack_frame(50, 50, 0, 0, 1, 0, 0));
        // home with control on, then both buttons with B at its upper clamp
        send_frame(pack_frame(100, 0, 0, 0, 0, 0, 1));
        send_frame(pack_frame(50, 50, 0, 0, 1, 0, 0));
        send_frame(pack_frame(0, 100, 0, 1, 1, 1, 1));
        send_frame(pack_frame(64, 64, 1, 1, 0, 0, 0));
    endtask

    task automatic test_limit_extremes();
        apply_limits('{0, 0, 0, 0, 0, 0});
        run_frames(60);
        apply_limits('{255, 200, 181, 255, 255, 255});
        run_frames(60);
        // lower clamps above upper clamps
        apply_limits('{180, 0, 180, 0, 0, 180});
        run_frames(60);
        apply_limits('{90, 90, 90, 90, 90, 90});
        run_frames(60);
        apply_limits('{A_LO_RESET, A_HI_RESET, B_LO_RESET, B_HI_RESET, Z_HI_RESET,
                       Z_HOME_RESET});
        run_frames(60);
    endtask

    task automatic test_random_limits();
        int unsigned pick [NUM_LIMITS];
        repeat (7) begin
            foreach (pick[i]) pick[i] = pick_limit();
            apply_limits(pick);
            tx_steady = ($urandom_range(3) == 0);
            rx_steady = ($urandom_range(3) == 0);
            run_frames(180);
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_steady_stream();
        settle_arm();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        run_frames(150);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        i_clk                 = 1'b0;
        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        frame_ch.valid        = 1'b0;
        frame_ch.stick_x      = '0;
        frame_ch.stick_y      = '0;
        frame_ch.raise_button = 1'b1;
        frame_ch.lower_button = 1'b1;
        frame_ch.grip_button  = 1'b1;
        frame_ch.control_off  = 1'b0;
        frame_ch.home_request = 1'b0;
        report_ch.ready       = 1'b0;

        arm_a           = ANGLE_RESET;
        arm_b           = ANGLE_RESET;
        arm_z           = ANGLE_RESET;
        grip_pos        = ANGLE_RESET;
        grip_toggle     = 1'b0;
        grip_btn_prev   = 1'b1;
        grip_is_closed  = 1'b0;
        lim[CFG_A_LO]   = A_LO_RESET;
        lim[CFG_A_HI]   = A_HI_RESET;
        lim[CFG_B_LO]   = B_LO_RESET;
        lim[CFG_B_HI]   = B_HI_RESET;
        lim[CFG_Z_HI]   = Z_HI_RESET;
        lim[CFG_Z_HOME] = Z_HOME_RESET;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_state();
        test_directed_frames();
        test_limit_extremes();
        test_random_limits();
        test_steady_stream();

        settle_arm();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### servo_jog_controller_unit.f
sv/sjc_pkg.sv
sv/sjc_if.sv
sv/servo_jog_controller_unit.sv
dv/servo_jog_controller_unit_tb.sv
